FILE: hw/rtl/bpmp_pkg.sv
// ----------------------------------------------------------------------------
// bpmp_pkg
// Shared constants, control word layout, microprogram and build-time
// modular arithmetic for the binomial product block.
// ----------------------------------------------------------------------------
`default_nettype none

package bpmp_pkg;

  // Field widths and defaults
  localparam int unsigned VAL_W          = 30;
  localparam int unsigned SIZE_W         = 12;
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 32;
  localparam int unsigned TABLE_SIZE_DEF = 4096;
  localparam int unsigned PC_W           = 5;

  // Modulus and Barrett constant floor(2^60 / p)
  localparam logic [VAL_W-1:0] PRIME_MOD  = 30'd1000000007;
  localparam logic [31:0]      BARRETT_MU = 32'((64'd1 << (2 * VAL_W)) / 64'(PRIME_MOD));
  localparam logic [31:0]      TWO_P      = 32'({PRIME_MOD, 1'b0});

  // Sequencer condition codes
  localparam logic [1:0] C_NEXT    = 2'd0;
  localparam logic [1:0] C_WAIT_IN = 2'd1;
  localparam logic [1:0] C_ZERO    = 2'd2;
  localparam logic [1:0] C_EMIT    = 2'd3;

  // Inverse-factorial read address select
  localparam logic [1:0] RD_NONE    = 2'd0;
  localparam logic [1:0] RD_TOPPICK = 2'd1;
  localparam logic [1:0] RD_PICK    = 2'd2;

  // Multiplier operand A select
  localparam logic [1:0] A_T    = 2'd0;
  localparam logic [1:0] A_PROD = 2'd1;
  localparam logic [1:0] A_XHI  = 2'd2;
  localparam logic [1:0] A_QHI  = 2'd3;

  // Multiplier operand B select
  localparam logic [2:0] B_INV  = 3'd0;
  localparam logic [2:0] B_FACT = 3'd1;
  localparam logic [2:0] B_T    = 3'd2;
  localparam logic [2:0] B_MU   = 3'd3;
  localparam logic [2:0] B_P    = 3'd4;

  // Reduced-result destination
  localparam logic [1:0] F_NONE = 2'd0;
  localparam logic [1:0] F_T    = 2'd1;
  localparam logic [1:0] F_PROD = 2'd2;

  // Program step addresses
  localparam logic [PC_W-1:0] PC_WAIT = 5'd0;
  localparam logic [PC_W-1:0] PC_SUM  = 5'd1;
  localparam logic [PC_W-1:0] PC_RD2  = 5'd2;
  localparam logic [PC_W-1:0] PC_M1   = 5'd3;
  localparam logic [PC_W-1:0] PC_M1Q  = 5'd4;
  localparam logic [PC_W-1:0] PC_M1P  = 5'd5;
  localparam logic [PC_W-1:0] PC_M1S  = 5'd6;
  localparam logic [PC_W-1:0] PC_M1F  = 5'd7;
  localparam logic [PC_W-1:0] PC_M2   = 5'd8;
  localparam logic [PC_W-1:0] PC_M2Q  = 5'd9;
  localparam logic [PC_W-1:0] PC_M2P  = 5'd10;
  localparam logic [PC_W-1:0] PC_M2S  = 5'd11;
  localparam logic [PC_W-1:0] PC_M2F  = 5'd12;
  localparam logic [PC_W-1:0] PC_M3   = 5'd13;
  localparam logic [PC_W-1:0] PC_M3Q  = 5'd14;
  localparam logic [PC_W-1:0] PC_M3P  = 5'd15;
  localparam logic [PC_W-1:0] PC_M3S  = 5'd16;
  localparam logic [PC_W-1:0] PC_M3F  = 5'd17;
  localparam logic [PC_W-1:0] PC_EMIT = 5'd18;

  typedef struct packed {
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
    logic            accept;
    logic [1:0]      rd_inv;
    logic            rd_fact;
    logic            chk_kill;
    logic            load_t;
    logic            mul_en;
    logic [1:0]      mul_a;
    logic [2:0]      mul_b;
    logic            save_x;
    logic            sub_en;
    logic [1:0]      fix_dst;
    logic            emit;
  } ctl_word_t;

  typedef struct packed {
    logic size_zero;
    logic last;
    logic out_busy;
  } dp_stat_t;

  // Microprogram: one control word per step
  function automatic ctl_word_t ucode(logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = '0;
    case (pc)
      PC_WAIT: begin
        w.cond   = C_WAIT_IN;
        w.accept = 1'b1;
      end
      PC_SUM: begin
        w.cond     = C_ZERO;
        w.target   = PC_EMIT;
        w.rd_inv   = RD_TOPPICK;
        w.chk_kill = 1'b1;
      end
      PC_RD2: begin
        w.rd_inv  = RD_PICK;
        w.rd_fact = 1'b1;
        w.load_t  = 1'b1;
      end
      PC_M1: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_T;
        w.mul_b  = B_INV;
      end
      PC_M2: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_T;
        w.mul_b  = B_FACT;
      end
      PC_M3: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_PROD;
        w.mul_b  = B_T;
      end
      // Barrett quotient estimate, keep low bits of x
      PC_M1Q, PC_M2Q, PC_M3Q: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_XHI;
        w.mul_b  = B_MU;
        w.save_x = 1'b1;
      end
      PC_M1P, PC_M2P, PC_M3P: begin
        w.mul_en = 1'b1;
        w.mul_a  = A_QHI;
        w.mul_b  = B_P;
      end
      PC_M1S, PC_M2S, PC_M3S: begin
        w.sub_en = 1'b1;
      end
      PC_M1F, PC_M2F: begin
        w.fix_dst = F_T;
      end
      PC_M3F: begin
        w.fix_dst = F_PROD;
      end
      PC_EMIT: begin
        w.cond   = C_EMIT;
        w.target = PC_WAIT;
        w.emit   = 1'b1;
      end
      default: begin
        w.cond   = C_ZERO;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

  // Build-time modular product
  function automatic logic [VAL_W-1:0] mod_mul(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [63:0] prd;
    prd = 64'(a) * 64'(b);
    return VAL_W'(prd % 64'(PRIME_MOD));
  endfunction

  // Build-time modular power (Fermat inverse)
  function automatic logic [VAL_W-1:0] mod_pow(logic [VAL_W-1:0] base, logic [VAL_W-1:0] expo);
    logic [VAL_W-1:0] acc;
    logic [VAL_W-1:0] sq;
    acc = VAL_W'(1);
    sq  = base;
    for (int k = 0; k < VAL_W; k++) begin
      if (expo[k]) acc = mod_mul(acc, sq);
      sq = mod_mul(sq, sq);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bpmp_tables.sv
// ----------------------------------------------------------------------------
// bpmp_tables
// Factorial and inverse-factorial ROMs, contents fixed at elaboration,
// one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmp_tables #(
  parameter int unsigned TABLE_SIZE = bpmp_pkg::TABLE_SIZE_DEF
) (
  input  wire                              clk,
  input  wire                              inv_en,
  input  wire  [$clog2(TABLE_SIZE)-1:0]    inv_addr,
  input  wire                              fact_en,
  input  wire  [$clog2(TABLE_SIZE)-1:0]    fact_addr,
  output logic [bpmp_pkg::VAL_W-1:0]       inv_rd,
  output logic [bpmp_pkg::VAL_W-1:0]       fact_rd
);
  import bpmp_pkg::*;

  localparam int unsigned ROM_BITS = TABLE_SIZE * VAL_W;

  // i! mod p, packed entry by entry
  function automatic logic [ROM_BITS-1:0] fact_fill();
    logic [ROM_BITS-1:0] v;
    logic [VAL_W-1:0]    f;
    v = '0;
    f = VAL_W'(1);
    v[VAL_W-1:0] = f;
    for (int i = 1; i < TABLE_SIZE; i++) begin
      f = mod_mul(f, VAL_W'(i));
      v[i*VAL_W +: VAL_W] = f;
    end
    return v;
  endfunction

  // (i!)^-1 mod p, walked down from the top entry
  function automatic logic [ROM_BITS-1:0] inv_fill();
    logic [ROM_BITS-1:0] v;
    logic [VAL_W-1:0]    f;
    logic [VAL_W-1:0]    g;
    v = '0;
    f = VAL_W'(1);
    for (int i = 1; i < TABLE_SIZE; i++) f = mod_mul(f, VAL_W'(i));
    g = mod_pow(f, PRIME_MOD - VAL_W'(2));
    v[(TABLE_SIZE-1)*VAL_W +: VAL_W] = g;
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      g = mod_mul(g, VAL_W'(i));
      v[(i-1)*VAL_W +: VAL_W] = g;
    end
    return v;
  endfunction

  localparam logic [ROM_BITS-1:0] FACT_ROM = fact_fill();
  localparam logic [ROM_BITS-1:0] INV_ROM  = inv_fill();

  logic [VAL_W-1:0] inv_rd_r;
  logic [VAL_W-1:0] fact_rd_r;

  // Registered reads, data held when not enabled
  always_ff @(posedge clk) begin
    if (inv_en) inv_rd_r <= INV_ROM[inv_addr*VAL_W +: VAL_W];
    if (fact_en) fact_rd_r <= FACT_ROM[fact_addr*VAL_W +: VAL_W];
  end

  assign inv_rd  = inv_rd_r;
  assign fact_rd = fact_rd_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bpmp_seq.sv
// ----------------------------------------------------------------------------
// bpmp_seq
// Microprogram sequencer: step counter, control word fetch and
// conditional jumps on input, zero size, last flag and output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmp_seq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire bpmp_pkg::dp_stat_t stat,
  output bpmp_pkg::ctl_word_t   ctl,
  output logic                  in_ready
);
  import bpmp_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ctl_word_t       word;

  assign word = ucode(pc_r);

  // Next step and gated strobes
  always_comb begin
    ctl    = word;
    pc_nxt = pc_r + PC_W'(1);
    case (word.cond)
      C_WAIT_IN: begin
        ctl.accept = word.accept & in_valid;
        if (!in_valid) pc_nxt = pc_r;
      end
      C_ZERO: begin
        if (stat.size_zero) pc_nxt = word.target;
      end
      C_EMIT: begin
        ctl.emit = 1'b0;
        if (!stat.last) begin
          pc_nxt = word.target;
        end else if (stat.out_busy) begin
          pc_nxt = pc_r;
        end else begin
          pc_nxt   = word.target;
          ctl.emit = word.emit;
        end
      end
      default: ;
    endcase
  end

  // No beat is taken while reset is held
  assign in_ready = (word.cond == C_WAIT_IN) & rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= PC_WAIT;
    else pc_r <= pc_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bpmp_dp.sv
// ----------------------------------------------------------------------------
// bpmp_dp
// Datapath: running sum and product, shared 32x32 multiplier with
// Barrett reduction mod p, table addressing and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmp_dp #(
  parameter int unsigned TABLE_SIZE = bpmp_pkg::TABLE_SIZE_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire bpmp_pkg::ctl_word_t         ctl,
  input  wire  [bpmp_pkg::SIZE_W-1:0]      in_size,
  input  wire                              in_last,
  input  wire                              out_ready,
  input  wire  [bpmp_pkg::VAL_W-1:0]       inv_rd,
  input  wire  [bpmp_pkg::VAL_W-1:0]       fact_rd,
  output logic                             inv_en,
  output logic [$clog2(TABLE_SIZE)-1:0]    inv_addr,
  output logic                             fact_en,
  output logic [$clog2(TABLE_SIZE)-1:0]    fact_addr,
  output bpmp_pkg::dp_stat_t               stat,
  output logic                             out_valid,
  output logic [bpmp_pkg::VAL_W-1:0]       out_count,
  output logic                             out_ovf
);
  import bpmp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_SIZE);
  localparam int unsigned W      = ((ADDR_W > SIZE_W) ? ADDR_W : SIZE_W) + 1;
  localparam logic [W-1:0]      SUM_MAX   = W'(TABLE_SIZE - 1);
  localparam logic [ADDR_W-1:0] SUM_SATUR = ADDR_W'(TABLE_SIZE - 1);

  // Control state
  logic [ADDR_W-1:0] sum_r, sum_nxt;
  logic              ovf_r, ovf_nxt;
  logic [VAL_W-1:0]  prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  // Working registers
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              last_r, last_nxt;
  logic              kill_r, kill_nxt;
  logic [VAL_W-1:0]  t_r, t_nxt;
  logic [31:0]       x_r, x_nxt;
  logic [63:0]       mul_r, mul_nxt;
  logic [31:0]       r_r, r_nxt;
  logic [VAL_W-1:0]  out_count_r, out_count_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic [W-1:0]      sum_add;
  logic [W-1:0]      toppick_w;
  logic [W-1:0]      pick_w;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [VAL_W-1:0]  fix_val;

  // Table addresses: s-1, s-x, x-1
  assign sum_add   = W'(sum_r) + W'(in_size);
  assign toppick_w = W'(sum_r) - W'(size_r);
  assign pick_w    = W'(size_r) - W'(1);
  assign inv_en    = (ctl.rd_inv != RD_NONE);
  assign inv_addr  = (ctl.rd_inv == RD_PICK) ? pick_w[ADDR_W-1:0] : toppick_w[ADDR_W-1:0];
  assign fact_en   = ctl.rd_fact;
  assign fact_addr = sum_r - ADDR_W'(1);

  // Shared multiplier operands
  always_comb begin
    case (ctl.mul_a)
      A_T:     mul_a = 32'(t_r);
      A_PROD:  mul_a = 32'(prod_r);
      A_XHI:   mul_a = 32'(mul_r[59:29]);
      A_QHI:   mul_a = mul_r[62:31];
      default: mul_a = '0;
    endcase
    case (ctl.mul_b)
      B_INV:   mul_b = 32'(inv_rd);
      B_FACT:  mul_b = 32'(fact_rd);
      B_T:     mul_b = 32'(t_r);
      B_MU:    mul_b = BARRETT_MU;
      B_P:     mul_b = 32'(PRIME_MOD);
      default: mul_b = '0;
    endcase
  end

  // Final Barrett correction, remainder below 3p
  always_comb begin
    if (r_r >= TWO_P) fix_val = VAL_W'(r_r - TWO_P);
    else if (r_r >= 32'(PRIME_MOD)) fix_val = VAL_W'(r_r - 32'(PRIME_MOD));
    else fix_val = VAL_W'(r_r);
  end

  // Next-state logic driven by the control word
  always_comb begin
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    prod_nxt      = prod_r;
    size_nxt      = size_r;
    last_nxt      = last_r;
    kill_nxt      = kill_r;
    t_nxt         = t_r;
    x_nxt         = x_r;
    mul_nxt       = mul_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;

    // Beat accepted: add size, saturate on overflow
    if (ctl.accept) begin
      size_nxt = in_size;
      last_nxt = in_last;
      if (sum_add > SUM_MAX) begin
        sum_nxt = SUM_SATUR;
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = sum_add[ADDR_W-1:0];
      end
    end

    // Coefficient is zero when x-1 exceeds s-1
    if (ctl.chk_kill) kill_nxt = (W'(size_r) > W'(sum_r));
    if (ctl.load_t) t_nxt = inv_rd;
    if (ctl.mul_en) mul_nxt = 64'(mul_a) * 64'(mul_b);
    if (ctl.save_x) x_nxt = mul_r[31:0];
    if (ctl.sub_en) r_nxt = x_r - mul_r[31:0];

    case (ctl.fix_dst)
      F_T:     t_nxt = kill_r ? '0 : fix_val;
      F_PROD:  prod_nxt = fix_val;
      default: ;
    endcase

    // Last beat of a case: load result, clear case state
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = ovf_r ? '0 : prod_r;
      out_ovf_nxt   = ovf_r;
      sum_nxt       = '0;
      prod_nxt      = VAL_W'(1);
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      prod_r      <= VAL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      prod_r      <= prod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    last_r      <= last_nxt;
    kill_r      <= kill_nxt;
    t_r         <= t_nxt;
    x_r         <= x_nxt;
    mul_r       <= mul_nxt;
    r_r         <= r_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign stat.size_zero = (size_r == '0);
  assign stat.last      = last_r;
  assign stat.out_busy  = out_valid_r & ~out_ready;
  assign out_valid      = out_valid_r;
  assign out_count      = out_count_r;
  assign out_ovf        = out_ovf_r;

endmodule

`default_nettype wire

FILE: hw/rtl/binomial_product_mod_prime.sv
// An item is taken only after the one before it is done. A last item also waits
// while the previous result beat is still pending. The work is set by the shared
// 32x32 multiplier: three modular products per item of nonzero size, each a
// multiply, two Barrett steps, a subtract and a correction.
// ----------------------------------------------------------------------------
// binomial_product_mod_prime
// Running product of C(s-1, x-1) mod 1000000007 over a stream of group
// sizes; one result per case on the last beat.
// Reset (rst_n low, synchronous): sum 0, product 1, overflow clear, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_product_mod_prime #(
  parameter int unsigned TABLE_SIZE = bpmp_pkg::TABLE_SIZE_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [bpmp_pkg::IN_TDATA_W-1:0]    in_tdata,   // [11:0] group_size
  input  wire                                in_tlast,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [bpmp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [29:0] count_mod
  output logic                               out_tuser   // [0] overflow
);
  import bpmp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_SIZE);

  ctl_word_t         ctl;
  dp_stat_t          stat;
  logic              inv_en;
  logic [ADDR_W-1:0] inv_addr;
  logic              fact_en;
  logic [ADDR_W-1:0] fact_addr;
  logic [VAL_W-1:0]  inv_rd;
  logic [VAL_W-1:0]  fact_rd;
  logic [VAL_W-1:0]  out_count;

  bpmp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_tready)
  );

  bpmp_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_size   (in_tdata[SIZE_W-1:0]),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .inv_rd    (inv_rd),
    .fact_rd   (fact_rd),
    .inv_en    (inv_en),
    .inv_addr  (inv_addr),
    .fact_en   (fact_en),
    .fact_addr (fact_addr),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_count (out_count),
    .out_ovf   (out_tuser)
  );

  bpmp_tables #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_tables (
    .clk       (clk),
    .inv_en    (inv_en),
    .inv_addr  (inv_addr),
    .fact_en   (fact_en),
    .fact_addr (fact_addr),
    .inv_rd    (inv_rd),
    .fact_rd   (fact_rd)
  );

  assign out_tdata = OUT_TDATA_W'(out_count);

endmodule

`default_nettype wire

FILE: bench/binomial_product_mod_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_product_mod_prime_test
// Streams cases of group sizes into the block with random gaps and
// backpressure, predicts each per-case binomial product locally from
// factorial tables built at time zero, and checks every result beat in order.
// ----------------------------------------------------------------------------

module binomial_product_mod_prime_test;

  localparam int unsigned TABLE_TOP  = bpmp_pkg::TABLE_SIZE_DEF - 1;
  localparam logic [63:0] MODULUS    = 64'd1000000007;
  localparam int unsigned GAP_MAX    = 17;
  localparam int unsigned IDLE_LIMIT = 500;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned ITEM_GOAL  = 945;

  // One group beat as queued for the driver
  typedef struct {
    logic [bpmp_pkg::SIZE_W-1:0] size;
    logic                        last;
    logic                        drain;  // hold off until all results are in
  } group_beat_t;

  // One expected case result
  typedef struct {
    logic [bpmp_pkg::VAL_W-1:0] count_mod;
    logic                       overflow;
  } case_count_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [bpmp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // [11:0] group_size
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [bpmp_pkg::OUT_TDATA_W-1:0] out_tdata;       // [29:0] count_mod
  logic                             out_tuser;       // [0] overflow

  binomial_product_mod_prime u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  group_beat_t group_q[$];
  case_count_t count_q[$];

  // Local factorial tables and running case state
  logic [bpmp_pkg::VAL_W-1:0]  fact_tab     [0:TABLE_TOP];
  logic [bpmp_pkg::VAL_W-1:0]  inv_fact_tab [0:TABLE_TOP];
  logic [bpmp_pkg::SIZE_W-1:0] sum_acc  = '0;
  logic [bpmp_pkg::VAL_W-1:0]  prod_acc = 30'd1;
  logic                        ovf_acc  = 1'b0;

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  logic        results_drained = 1'b1;

  int unsigned tx_wait = 0;
  logic        tx_burst = 1'b0;
  int unsigned rx_wait = 0;
  logic        rx_burst = 1'b0;

  function automatic logic [29:0] mulmod(input logic [29:0] a, input logic [29:0] b);
    logic [63:0] full;
    full = 64'(a) * 64'(b);
    return 30'(full % MODULUS);
  endfunction

  // C(top, pick) mod p from the tables
  function automatic logic [29:0] binom(input logic [11:0] top, input logic [11:0] pick);
    if (pick > top) return '0;
    return mulmod(fact_tab[top], mulmod(inv_fact_tab[top - pick], inv_fact_tab[pick]));
  endfunction

  // Fold one accepted group into the case; queue the count on the last group
  task automatic fold_group(input logic [11:0] size, input logic last);
    logic [12:0] grown;
    case_count_t res;
    if (size != '0) begin
      grown = 13'(sum_acc) + 13'(size);
      if (grown > 13'(TABLE_TOP)) begin
        grown   = 13'(TABLE_TOP);
        ovf_acc = 1'b1;
      end
      sum_acc  = grown[11:0];
      prod_acc = mulmod(prod_acc, binom(sum_acc - 12'd1, size - 12'd1));
    end
    if (last) begin
      res.count_mod = ovf_acc ? '0 : prod_acc;
      res.overflow  = ovf_acc;
      count_q.push_back(res);
      sum_acc  = '0;
      prod_acc = 30'd1;
      ovf_acc  = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic add_group(input int unsigned size, input bit last, input bit drain);
    group_beat_t g;
    g.size  = size[11:0];
    g.last  = last;
    g.drain = drain;
    group_q.push_back(g);
  endtask

  // One random case, always closed by a last beat
  task automatic add_random_case(input bit drain);
    int unsigned kind;
    int unsigned n_groups;
    int unsigned room;
    int unsigned size;
    kind     = $urandom_range(0, 9);
    n_groups = $urandom_range(1, 8);
    room     = TABLE_TOP;
    for (int g = 0; g < n_groups; g++) begin
      if (kind == 7)
        size = (g == 0) ? $urandom_range(3000, TABLE_TOP) : $urandom_range(1, TABLE_TOP);
      else if (kind >= 8)
        size = $urandom_range(0, TABLE_TOP);
      else if (room == 0 || $urandom_range(0, 9) == 0)
        size = 0;
      else if ($urandom_range(0, 7) == 0)
        size = $urandom_range(1, room);
      else
        size = $urandom_range(1, (room < 64) ? room : 64);
      room = (size <= room) ? room - size : 0;
      add_group(size, g == n_groups - 1, drain && g == 0);
    end
  endtask

  // Driver: one beat on the bus at a time, random gap after each outside bursts
  always @(posedge clk) begin
    group_beat_t nxt;
    logic        took;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      tx_wait   <= 0;
    end else begin
      took = in_tvalid && in_tready;
      if (took || !in_tvalid) begin
        if (tx_wait != 0) begin
          tx_wait   <= tx_wait - 1;
          in_tvalid <= 1'b0;
        end else if (group_q.size() != 0 &&
                     !(group_q[0].drain && (took || !results_drained))) begin
          nxt = group_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0000, nxt.size};
          in_tlast  <= nxt.last;
          if ($urandom_range(0, 31) == 0) tx_burst <= !tx_burst;
          tx_wait   <= tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: stall drawn per beat, counted down mostly while valid
  always @(posedge clk) begin
    int unsigned hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 31) == 0) rx_burst <= !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      rx_wait    <= hold;
      out_tready <= (hold == 0);
    end else if (!out_tready) begin
      if (rx_wait == 0) out_tready <= 1'b1;
      else if (out_tvalid || $urandom_range(0, 1) == 1) rx_wait <= rx_wait - 1;
    end
  end

  // Monitor: predict on accepted groups, check accepted results
  always @(posedge clk) begin
    case_count_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) fold_group(in_tdata[11:0], in_tlast);
      if (out_tvalid && out_tready) begin
        if (count_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat count=%0d ovf=%0b",
                                    out_tdata[29:0], out_tuser));
        end else begin
          want = count_q.pop_front();
          if (out_tdata[29:0] !== want.count_mod)
            report_mismatch($sformatf("count_mod got %0d want %0d",
                                      out_tdata[29:0], want.count_mod));
          if (out_tuser !== want.overflow)
            report_mismatch($sformatf("overflow got %0b want %0b",
                                      out_tuser, want.overflow));
        end
      end
      results_drained <= (count_q.size() == 0);
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [29:0] base;
    logic [29:0] acc;
    logic [29:0] expo;

    // Factorials and their inverses (Fermat on the top entry, then downward)
    fact_tab[0] = 30'd1;
    for (int i = 1; i <= TABLE_TOP; i++) fact_tab[i] = mulmod(fact_tab[i - 1], 30'(i));
    base = fact_tab[TABLE_TOP];
    acc  = 30'd1;
    expo = 30'(MODULUS - 64'd2);
    while (expo != '0) begin
      if (expo[0]) acc = mulmod(acc, base);
      base = mulmod(base, base);
      expo = expo >> 1;
    end
    inv_fact_tab[TABLE_TOP] = acc;
    for (int i = TABLE_TOP; i > 0; i--)
      inv_fact_tab[i - 1] = mulmod(inv_fact_tab[i], 30'(i));

    // Directed cases: field extremes, exact fill, overflow, empty groups
    add_group(1, 1, 0);
    add_group(0, 1, 0);
    add_group(TABLE_TOP, 1, 0);
    add_group(2, 0, 0);
    add_group(3, 1, 0);
    add_group(TABLE_TOP, 0, 0);
    add_group(1, 1, 0);
    add_group(2048, 0, 0);
    add_group(2048, 1, 0);
    add_group(2047, 0, 0);
    add_group(2048, 1, 0);
    add_group(0, 0, 0);
    add_group(5, 0, 0);
    add_group(0, 0, 0);
    add_group(7, 1, 0);
    add_group(TABLE_TOP, 0, 0);
    add_group(0, 1, 0);
    add_group(4, 0, 0);
    add_group(4, 1, 0);

    // Random cases; the first one waits for every directed result
    add_random_case(1'b1);
    while (group_q.size() < ITEM_GOAL) add_random_case($urandom_range(0, 39) == 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (group_q.size() != 0 || in_tvalid) @(posedge clk);
    while (count_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
